### sv/tth_pkg.sv
// Shared types, character codes and string-update functions for the time text parser.
package tth_pkg;

    localparam int NumDigits = 6;

    localparam logic [2:0] CountFull = 3'd7;
    localparam logic [2:0] CountMax  = 3'd6;
    localparam logic [6:0] HourNoon  = 7'd12;
    localparam logic [6:0] HourTwenty = 7'd20;
    localparam logic [6:0] HourTen   = 7'd10;

    // ASCII codes; letters are compared after folding to lower case
    localparam logic [7:0] CaseBit    = 8'h20;
    localparam logic [7:0] CharLowO   = 8'h6F;
    localparam logic [7:0] CharLowL   = 8'h6C;
    localparam logic [7:0] CharLowI   = 8'h69;
    localparam logic [7:0] CharLowA   = 8'h61;
    localparam logic [7:0] CharLowP   = 8'h70;
    localparam logic [7:0] CharDot    = 8'h2E;
    localparam logic [7:0] CharColon  = 8'h3A;
    localparam logic [7:0] CharZero   = 8'h30;
    localparam logic [7:0] CharNine   = 8'h39;

    typedef logic [3:0] t_digit;
    typedef t_digit [NumDigits-1:0] t_digits;

    typedef enum logic [1:0] {
        MARK_NONE = 2'd0,
        MARK_AM   = 2'd1,
        MARK_PM   = 2'd2
    } t_mark;

    typedef enum logic [1:0] {
        KIND_CLOCK   = 2'd0,
        KIND_MINUTES = 2'd1,
        KIND_SECONDS = 2'd2
    } t_kind;

    typedef struct packed {
        t_digits    digits;
        logic [2:0] count;
        t_mark      mark;
    } t_text;

    // At count 1, 3 or allowed 5: move the last digit one place right, a zero before it.
    function automatic t_text pad_pair(t_text s, logic allow_five);
        t_text n;
        n = s;
        if (s.count == 3'd1 || s.count == 3'd3 || (allow_five && s.count == 3'd5)) begin
            for (int i = 1; i < NumDigits; i++) begin
                if (s.count == 3'(i)) begin
                    n.digits[i]   = s.digits[i-1];
                    n.digits[i-1] = '0;
                end
            end
            n.count = s.count + 3'd1;
        end
        return n;
    endfunction

    // Fold one character into the string state.
    function automatic t_text take_char(t_text s, logic [7:0] c);
        t_text      n;
        logic [7:0] lc;
        logic       push;
        t_digit     d;
        n    = s;
        lc   = c | CaseBit;
        push = 1'b0;
        d    = '0;
        if (lc == CharLowO) begin
            push = 1'b1;
        end else if (lc == CharLowL || lc == CharLowI) begin
            push = 1'b1;
            d    = 4'd1;
        end else if (lc == CharLowA) begin
            n.mark = MARK_AM;
        end else if (lc == CharLowP) begin
            n.mark = MARK_PM;
        end else if (c == CharDot || c == CharColon) begin
            n = pad_pair(s, 1'b0);
        end else if (c >= CharZero && c <= CharNine) begin
            push = 1'b1;
            d    = c[3:0];
        end
        if (push) begin
            if (s.count < CountMax) begin
                for (int i = 0; i < NumDigits; i++) begin
                    if (s.count == 3'(i)) begin
                        n.digits[i] = d;
                    end
                end
                n.count = s.count + 3'd1;
            end else begin
                n.count = CountFull;
            end
        end
        return n;
    endfunction

endpackage

### sv/time_text_to_hhmmss.sv
// Top level: typed time string in, one HHMMSS result per string out.
// Path: an accepted character is held in the input register, then folded into the
//   string state; a last character instead loads the result register.
// Throughput: one character per cycle, set by the combinational update of the
//   six-digit buffer; a last character waits while a held result is not taken.
// Reset: synchronous, active low; clears both stage valids and the string state.
module time_text_to_hhmmss (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_s_axis_tlast,   // end_of_text
    input  logic [2:0]  i_s_axis_tuser,   // [0] char_valid, [2:1] time_kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [3:0] hour_tens, [7:4] hour_units,
                                          // [11:8] minute_tens, [15:12] minute_units,
                                          // [19:16] second_tens, [23:20] second_units
    output logic [0:0]  o_m_axis_tuser    // [0] is_blank
);
    import tth_pkg::*;

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_cvalid;
    logic       r_in_last;
    t_kind      r_in_kind;

    // string state carried between transactions
    t_text      r_text;
    t_text      n_text;

    // result stage
    logic       r_out_valid;
    t_digits    r_out_digits;
    logic       r_out_blank;

    t_digits    fin_digits;
    logic       fin_blank;
    logic       advance;

    // A plain character never needs the result register; a last one needs it free.
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    // A valid character on the last transaction is taken in before finishing.
    assign n_text = r_in_cvalid ? take_char(r_text, r_in_char) : r_text;

    tth_finish u_finish (
        .i_text   (n_text),
        .i_kind   (r_in_kind),
        .o_digits (fin_digits),
        .o_blank  (fin_blank)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_text      <= t_text'('0);
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                // drop the string state once its result is issued
                r_text <= r_in_last ? t_text'('0) : n_text;
            end
            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: hold until the next load
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_char   <= i_s_axis_tdata;
            r_in_cvalid <= i_s_axis_tuser[0];
            r_in_last   <= i_s_axis_tlast;
            r_in_kind   <= t_kind'(i_s_axis_tuser[2:1]);
        end
        if (advance && r_in_last) begin
            r_out_digits <= fin_digits;
            r_out_blank  <= fin_blank;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_digits;
    assign o_m_axis_tuser[0] = r_out_blank;

    // a finished string leaves the state at its reset value
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_text.count == 3'd0 && r_text.mark == MARK_NONE))
        else $error("string state not cleared after last character");

    // an empty buffer holds only zero digits
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_text.count == 3'd0) |-> (r_text.digits == t_digits'('0)))
        else $error("digits present with zero count");

    // a blank result carries no digits
    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == 24'h000000))
        else $error("blank result with nonzero digits");

    // a new result appears only from an advancing last character
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(advance && r_in_last))
        else $error("result without a last character");

endmodule

### sv/tth_finish.sv
// Finishing logic: pad, zero-fill, AM/PM correction and kind shift of the digit buffer.
module tth_finish (
    input  tth_pkg::t_text   i_text,
    input  tth_pkg::t_kind   i_kind,
    output tth_pkg::t_digits o_digits,
    output logic             o_blank
);
    import tth_pkg::*;

    t_text      padded;
    t_digits    filled;
    t_digits    fixed;
    logic [6:0] hour;
    logic [6:0] hour_adj;
    logic       adjust;

    always_comb begin
        padded = pad_pair(i_text, 1'b1);
        for (int i = 0; i < NumDigits; i++) begin
            filled[i] = (3'(i) < padded.count) ? padded.digits[i] : '0;
        end
    end

    assign hour = 7'(filled[0]) * HourTen + 7'(filled[1]);
    // an empty string keeps its zero digits whatever mark was seen
    assign adjust = (padded.count != 3'd0) &&
                    ((padded.mark == MARK_AM && hour == HourNoon) ||
                     (padded.mark == MARK_PM && hour < HourNoon));
    assign hour_adj = hour + HourNoon;

    always_comb begin
        fixed = filled;
        if (adjust) begin
            // adjusted hour lies in 12..24
            if (hour_adj >= HourTwenty) begin
                fixed[0] = 4'd2;
                fixed[1] = 4'(hour_adj - HourTwenty);
            end else begin
                fixed[0] = 4'd1;
                fixed[1] = 4'(hour_adj - HourTen);
            end
        end
    end

    always_comb begin
        case (i_kind)
            KIND_MINUTES: o_digits = {fixed[3:0], 8'h00};
            KIND_SECONDS: o_digits = {fixed[1:0], 16'h0000};
            default:      o_digits = fixed;
        endcase
    end

    assign o_blank = (i_text.count == 3'd0);

endmodule

### verif/hhmmss_result_checker.sv
// Checker for the time text parser: predicts each HHMMSS result and compares it.
`timescale 1ns / 100ps

module hhmmss_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    input  logic        i_s_tlast,   // end_of_text
    input  logic [2:0]  i_s_tuser,   // [0] char_valid, [2:1] time_kind
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // [3:0] hour_tens ... [23:20] second_units
    input  logic [0:0]  i_m_tuser,   // [0] is_blank
    output int          o_fail_count,
    output int          o_pending
);
    import tth_pkg::*;

    typedef struct packed {
        t_digits digits;
        logic    blank;
    } t_clock_result;

    t_digit        digit_store [NumDigits];
    logic [2:0]    digits_held;
    t_mark         mark_seen;
    t_clock_result expected_times [$];

    function automatic void clear_text();
        for (int i = 0; i < NumDigits; i++) digit_store[i] = '0;
        digits_held = '0;
        mark_seen   = MARK_NONE;
    endfunction

    function automatic void store_digit(t_digit d);
        if (digits_held < CountMax) begin
            digit_store[digits_held] = d;
            digits_held = digits_held + 3'd1;
        end else begin
            digits_held = CountFull;
        end
    endfunction

    // shift the newest digit one place right, zero in front of it
    function automatic void split_last();
        digit_store[digits_held]        = digit_store[digits_held - 3'd1];
        digit_store[digits_held - 3'd1] = '0;
        digits_held = digits_held + 3'd1;
    endfunction

    function automatic void fold_char(logic [7:0] c);
        case (c)
            "O", "o":           store_digit(4'd0);
            "L", "l", "I", "i": store_digit(4'd1);
            "A", "a":           mark_seen = MARK_AM;
            "P", "p":           mark_seen = MARK_PM;
            CharDot, CharColon: begin
                if (digits_held == 3'd1 || digits_held == 3'd3) split_last();
            end
            default: begin
                if (c >= CharZero && c <= CharNine) store_digit(c[3:0]);
            end
        endcase
    endfunction

    function automatic t_clock_result finish_text(logic [1:0] kind);
        t_clock_result r;
        int            hour;
        int            places;
        r.digits = '0;
        r.blank  = 1'b0;
        if (digits_held == 3'd0) begin
            r.blank = 1'b1;
        end else begin
            if (digits_held == 3'd1 || digits_held == 3'd3 || digits_held == 3'd5) split_last();
            for (int i = 0; i < NumDigits; i++) begin
                r.digits[i] = (i < int'(digits_held)) ? digit_store[i] : 4'd0;
            end
            hour = int'(r.digits[0]) * 10 + int'(r.digits[1]);
            if ((mark_seen == MARK_AM && hour == 12) || (mark_seen == MARK_PM && hour < 12)) begin
                hour = hour + 12;
                r.digits[0] = 4'(hour / 10);
                r.digits[1] = 4'(hour % 10);
            end
            places = (kind == KIND_MINUTES) ? 2 : (kind == KIND_SECONDS) ? 4 : 0;
            for (int i = NumDigits - 1; i >= 0; i--) begin
                r.digits[i] = (i >= places) ? r.digits[i - places] : 4'd0;
            end
        end
        clear_text();
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_clock_result want;
        t_clock_result got;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            clear_text();
            expected_times.delete();
            o_fail_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0]) fold_char(i_s_tdata);
                if (i_s_tlast) expected_times.push_back(finish_text(i_s_tuser[2:1]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.digits = i_m_tdata;
                got.blank  = i_m_tuser[0];
                if (expected_times.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual digits %h blank %0b",
                             $time, got.digits, got.blank);
                    errs++;
                end else begin
                    want = expected_times.pop_front();
                    for (int i = 0; i < NumDigits; i++) begin
                        if (got.digits[i] !== want.digits[i]) begin
                            $display("%0t: digit %0d mismatch, expected %0d, actual %0d",
                                     $time, i, want.digits[i], got.digits[i]);
                            errs++;
                        end
                    end
                    if (got.blank !== want.blank) begin
                        $display("%0t: blank flag mismatch, expected %0b, actual %0b",
                                 $time, want.blank, got.blank);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
        o_pending <= expected_times.size();
    end

endmodule

### verif/tb_time_text_to_hhmmss.sv
// Testbench top for the time text parser: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps

module tb_time_text_to_hhmmss;
    import tth_pkg::*;

    localparam int         ItemTarget  = 1350;
    localparam int         HoldCycles  = 400;
    localparam int         StallLimit  = 3000;
    localparam int         IdlePercent = 22;
    localparam logic [1:0] KindSpare   = 2'd3;   // unused kind, behaves as clock

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    // sender side
    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = '0;     // [7:0] char_code
    logic        s_last  = 1'b0;   // end_of_text
    logic [2:0]  s_user  = '0;     // [0] char_valid, [2:1] time_kind
    logic        s_ready;

    // receiver side
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_data;           // six 4-bit digits, hour_tens in [3:0]
    logic [0:0]  m_user;           // [0] is_blank

    int          fail_count;
    int          pending;
    int          items_sent  = 0;
    int          idle_cycles = 0;

    // traffic shaping shared by sender and receiver
    logic        quiet      = 1'b0;  // suppress random idling on both sides
    int          hold_reqs  = 0;     // bumped by stimulus to ask for a receiver hold-off
    int          holds_done = 0;
    int          hold_left  = 0;

    // one string under construction: bit 8 is char_valid, bits 7:0 the character
    logic [8:0]  text_q [$];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    time_text_to_hhmmss dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    hhmmss_result_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tlast    (s_last),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tuser    (m_user),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: random back-pressure, or a long hold-off when stimulus asks for one.
    // The hold-off length is counted here so the sender keeps pushing meanwhile.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != holds_done) begin
            m_ready    <= 1'b0;
            hold_left  <= HoldCycles;
            holds_done <= holds_done + 1;
        end else begin
            m_ready <= quiet || ($urandom_range(99) >= IdlePercent);
        end
    end

    // Count cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: end the run when traffic stalls for too long.
    initial begin
        while (idle_cycles < StallLimit) @(posedge i_clk);
        $display("** time_text_to_hhmmss: FAILED **");
        $finish;
    end

    // Offer one character and hold it until the block takes it.
    task automatic send_item(input logic [8:0] item, input logic last, input logic [1:0] kind);
        while (!quiet && $urandom_range(99) < IdlePercent) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= item[7:0];
        s_last  <= last;
        s_user  <= {kind, item[8]};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        if (item[8] || last) items_sent++;
    endtask

    // Send the queued string; the final character carries tlast and the kind.
    // An empty queue becomes a single empty character that closes the string.
    task automatic send_text(input logic [1:0] kind);
        logic [8:0] item;
        if (text_q.size() == 0) text_q.push_back({1'b0, 8'($urandom_range(255))});
        while (text_q.size() != 0) begin
            item = text_q.pop_front();
            send_item(item, text_q.size() == 0,
                      (text_q.size() == 0) ? kind : 2'($urandom_range(3)));
        end
    endtask

    task automatic send_string(input string str, input logic [1:0] kind);
        for (int i = 0; i < str.len(); i++) text_q.push_back({1'b1, 8'(str[i])});
        send_text(kind);
    endtask

    // Drop valid and wait until every predicted result has been received.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_digit();
        if ($urandom_range(9) != 0) return CharZero + 8'($urandom_range(9));
        case ($urandom_range(5))
            0:       return "O";
            1:       return "o";
            2:       return "L";
            3:       return "l";
            4:       return "I";
            default: return "i";
        endcase
    endfunction

    function automatic logic [7:0] pick_mark();
        case ($urandom_range(3))
            0:       return "A";
            1:       return "a";
            2:       return "P";
            default: return "p";
        endcase
    endfunction

    function automatic logic [7:0] pick_separator();
        return $urandom_range(1) ? CharColon : CharDot;
    endfunction

    // Build either a well-formed clock string or a burst of mixed noise.
    task automatic build_random_text();
        int pick;
        if ($urandom_range(99) < 65) begin
            // hour of one or two digits, then minutes, maybe seconds, maybe a mark
            repeat ($urandom_range(1, 2)) text_q.push_back({1'b1, pick_digit()});
            text_q.push_back({1'b1, pick_separator()});
            repeat (2) text_q.push_back({1'b1, pick_digit()});
            if ($urandom_range(1)) begin
                text_q.push_back({1'b1, pick_separator()});
                repeat ($urandom_range(1, 3)) text_q.push_back({1'b1, pick_digit()});
            end
            if ($urandom_range(99) < 45) begin
                if ($urandom_range(1)) text_q.push_back({1'b1, 8'h20});
                text_q.push_back({1'b1, pick_mark()});
                if ($urandom_range(1)) text_q.push_back({1'b1, 8'h6D});
            end
            if ($urandom_range(9) == 0) text_q.push_back({1'b0, 8'($urandom_range(255))});
        end else begin
            repeat ($urandom_range(0, 9)) begin
                pick = $urandom_range(99);
                if (pick < 45)      text_q.push_back({1'b1, pick_digit()});
                else if (pick < 60) text_q.push_back({1'b1, pick_separator()});
                else if (pick < 72) text_q.push_back({1'b1, pick_mark()});
                else if (pick < 85) text_q.push_back({1'b0, 8'($urandom_range(255))});
                else                text_q.push_back({1'b1, 8'($urandom_range(255))});
            end
        end
    endtask

    initial begin
        bit held_off;
        bit paused;
        held_off = 1'b0;
        paused   = 1'b0;

        // hold reset, then release it for good
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed strings: blank, separator after one and three digits, both marks,
        // noon with AM, letter digits, overflow past six digits, every kind
        send_string("", KIND_CLOCK);
        send_string("1:5P", KIND_CLOCK);
        send_string("12A", KindSpare);
        send_string("OlI98765", KIND_SECONDS);
        send_string("123.4p", KIND_MINUTES);
        send_string("7", KIND_MINUTES);
        text_q.push_back({1'b1, 8'hFF});
        send_text(KindSpare);

        // random strings, with one receiver hold-off, one drain and a quiet stretch
        while (items_sent < ItemTarget) begin
            if (!held_off && items_sent >= 350) begin
                held_off = 1'b1;
                hold_reqs <= hold_reqs + 1;
            end
            if (!paused && items_sent >= 500) begin
                paused = 1'b1;
                wait_for_results();
            end
            quiet <= (items_sent >= 650 && items_sent < 950);
            build_random_text();
            send_text(2'($urandom_range(3)));
        end

        // let the last result drain, then let the pipeline settle before the verdict
        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** time_text_to_hhmmss: PASSED **");
        end else begin
            $display("** time_text_to_hhmmss: FAILED **");
        end
        $finish;
    end

endmodule

### time_text_to_hhmmss.f
sv/tth_pkg.sv
sv/tth_finish.sv
sv/time_text_to_hhmmss.sv
verif/hhmmss_result_checker.sv
verif/tb_time_text_to_hhmmss.sv
